### rtl/cht_pkg.sv
package cht_pkg;

    localparam int VALUE_W   = 31;
    localparam int IDX_W     = 3;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_DELETED   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### rtl/cht_if.sv
interface cht_req_if;
    import cht_pkg::*;

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    logic [VALUE_W-1:0]   item_value;

    modport source (output valid, output kind, output item_value, input ready);
    modport sink   (input valid, input kind, input item_value, output ready);
endinterface

interface cht_rsp_if;
    import cht_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic [IDX_W-1:0]   bucket_index;

    modport source (output valid, output status, output bucket_index, input ready);
    modport sink   (input valid, input status, input bucket_index, output ready);
endinterface

### rtl/cht_ram.sv
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/cht_front.sv
module cht_front #(
    parameter int NUM_BUCKETS = 8
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    cht_req_if.sink                                          req,
    input  logic                                             clearing,
    input  cht_pkg::q_stat_t                                 q_stat,
    output logic                                             push,
    output logic [cht_pkg::VALUE_W+$clog2(NUM_BUCKETS):0]    push_data
);
    import cht_pkg::*;

    localparam int BW      = $clog2(NUM_BUCKETS);
    localparam int SHIFT   = VALUE_W + BW;
    localparam int RECIP_W = VALUE_W + 2;
    localparam int PROD_W  = VALUE_W + RECIP_W;
    localparam logic [63:0] RECIP_64 =
        ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_64);
    localparam logic [BW-1:0]      NB_LOW = BW'(NUM_BUCKETS);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } fstate_t;

    fstate_t            state_reg;
    kind_t              kind_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [BW-1:0]      quo_reg;

    logic               accept;
    logic [PROD_W-1:0]  product;
    logic [BW-1:0]      rem;

    // The quotient comes from a multiplication by the rounded-up reciprocal
    // of the bucket count; only its low bits are needed for the remainder.
    always_comb
    begin
        req.ready = (state_reg == F_IDLE) && !clearing;
        accept    = req.valid && req.ready;
        product   = PROD_W'(val_reg) * PROD_W'(RECIP);
        rem       = val_reg[BW-1:0] - BW'(quo_reg * NB_LOW);
        push      = (state_reg == F_PUSH) && !q_stat.full;
        push_data = {kind_reg, val_reg, rem};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            val_reg  <= req.item_value;
        end
        if (state_reg == F_MUL)
        begin
            quo_reg <= product[SHIFT +: BW];
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("Front pushed an item into a full queue.");
`endif
endmodule

### rtl/cht_queue.sv
module cht_queue #(
    parameter int WIDTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  pop_data,
    output cht_pkg::q_stat_t  q_stat
);
    import cht_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;

    always_comb
    begin
        q_stat.full  = (cnt_reg == 2'd2);
        q_stat.empty = (cnt_reg == 2'd0);
        pop_data     = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### rtl/cht_back.sv
module cht_back #(
    parameter int NUM_BUCKETS  = 8,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [cht_pkg::VALUE_W+$clog2(NUM_BUCKETS):0]    pop_data,
    input  cht_pkg::q_stat_t                                 q_stat,
    output logic                                             pop,
    output logic                                             clearing,
    cht_rsp_if.source                                        rsp
);
    import cht_pkg::*;

    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int QW    = 1 + VALUE_W + BW;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int ENT_W = BUCKET_DEPTH * VALUE_W;
    localparam int ROW_W = FW + ENT_W;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EXEC
    } bstate_t;

    bstate_t            state_reg;
    logic [BW-1:0]      clr_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [IDX_W-1:0]   idx_reg;
    kind_t              cur_kind_reg;
    logic [VALUE_W-1:0] cur_val_reg;
    logic [BW-1:0]      cur_b_reg;

    logic               out_ok;
    logic               wr_en;
    logic [BW-1:0]      wr_addr;
    logic [ROW_W-1:0]   wr_data;
    logic [ROW_W-1:0]   rd_data;
    logic [FW-1:0]      fill;
    logic [FW-1:0]      new_fill;
    logic [VALUE_W-1:0] slots     [BUCKET_DEPTH];
    logic [VALUE_W-1:0] new_slots [BUCKET_DEPTH];
    logic [ENT_W-1:0]   new_ent;
    logic [BUCKET_DEPTH-1:0] shift_sel;
    logic               seen;
    logic               is_full;
    status_t            new_status;

    cht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (pop),
        .rd_addr (pop_data[BW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_ok   = !out_valid_reg || rsp.ready;
        pop      = (state_reg == B_IDLE) && !q_stat.empty;
        clearing = (state_reg == B_CLEAR);
        fill     = rd_data[ENT_W +: FW];
        is_full  = (fill >= FW'(BUCKET_DEPTH));
        seen     = 1'b0;
        for (int j = 0; j < BUCKET_DEPTH; j++)
        begin
            slots[j]     = rd_data[j*VALUE_W +: VALUE_W];
            seen         = seen || ((FW'(j) < fill) && (slots[j] == cur_val_reg));
            shift_sel[j] = seen;
            new_slots[j] = slots[j];
        end

        if (cur_kind_reg == KIND_INSERT)
        begin
            if (is_full)
            begin
                new_fill   = fill;
                new_status = STATUS_FULL;
            end
            else
            begin
                for (int j = 0; j < BUCKET_DEPTH; j++)
                begin
                    if (FW'(j) == fill)
                    begin
                        new_slots[j] = cur_val_reg;
                    end
                end
                new_fill   = fill + FW'(1);
                new_status = STATUS_INSERTED;
            end
        end
        else
        begin
            // Entries after the first match move down one slot.
            for (int j = 0; j < BUCKET_DEPTH - 1; j++)
            begin
                if (shift_sel[j])
                begin
                    new_slots[j] = slots[j+1];
                end
            end
            if (seen)
            begin
                new_fill   = fill - FW'(1);
                new_status = STATUS_DELETED;
            end
            else
            begin
                new_fill   = fill;
                new_status = STATUS_NOT_FOUND;
            end
        end

        for (int j = 0; j < BUCKET_DEPTH; j++)
        begin
            new_ent[j*VALUE_W +: VALUE_W] = new_slots[j];
        end

        wr_en   = 1'b0;
        wr_addr = cur_b_reg;
        wr_data = {new_fill, new_ent};
        if (state_reg == B_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if ((state_reg == B_EXEC) && out_ok)
        begin
            wr_en = 1'b1;
        end

        rsp.valid        = out_valid_reg;
        rsp.status       = status_reg;
        rsp.bucket_index = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_INSERTED;
            idx_reg       <= '0;
        end
        else
        begin
            if ((state_reg == B_EXEC) && out_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= B_EXEC;
                    end
                end
                B_EXEC:
                begin
                    if (out_ok)
                    begin
                        state_reg     <= B_IDLE;
                        status_reg    <= new_status;
                        idx_reg       <= IDX_W'(cur_b_reg);
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_kind_reg <= kind_t'(pop_data[QW-1]);
            cur_val_reg  <= pop_data[BW +: VALUE_W];
            cur_b_reg    <= pop_data[BW-1:0];
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("Back took an item from an empty queue.");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EXEC) |-> (fill <= FW'(BUCKET_DEPTH)))
        else $error("Bucket fill count is above the bucket depth.");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !out_valid_reg)
        else $error("A result was shown during the clearing pass.");

    a_delete_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_EXEC) && out_ok && (new_status == STATUS_DELETED))
        |-> (fill != '0))
        else $error("A delete succeeded on an empty bucket.");

    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && pop))
        else $error("Bucket memory was read and written in the same cycle.");
`endif
endmodule

### rtl/chained_hash_table_insert_delete.sv
// Hash table of NUM_BUCKETS buckets, each a list of up to BUCKET_DEPTH values
// kept in insertion order.
// The req channel takes one item per request: kind selects insert or delete,
// item_value is the value. The rsp channel returns one item per request with
// the status and the low three bits of the bucket number (value mod
// NUM_BUCKETS). Both channels use valid and ready.
// The front part computes the bucket number by multiplying the value with a
// reciprocal of NUM_BUCKETS in the cycle after acceptance and offers the item
// to the queue in the cycle after that, waiting while the queue is full; it
// takes no new item until the last one is in the queue, and this sets the
// throughput. A two-entry queue feeds the back part, which reads the bucket
// row when it takes an item, then compares all slots at once and writes the
// row back, registering the result in the output register.
// After reset the block clears the fill counts of all buckets, one bucket a
// cycle, and does not accept items until it is done.
// When the receiver stalls, the result waits in the output register, the
// back part stops, the queue fills and the front part then drops ready.
module chained_hash_table_insert_delete #(
    parameter int NUM_BUCKETS  = 8,
    parameter int BUCKET_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    cht_req_if.sink    req,
    cht_rsp_if.source  rsp
);
    import cht_pkg::*;

    localparam int QW = 1 + VALUE_W + $clog2(NUM_BUCKETS);

    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_pop;
    logic [QW-1:0] q_pop_data;
    q_stat_t       q_stat;
    logic          clearing;

    cht_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .clearing  (clearing),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    cht_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .q_stat    (q_stat)
    );

    cht_back #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (q_pop_data),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .clearing (clearing),
        .rsp      (rsp)
    );
endmodule
